FILE: rtl/frm_pkg.sv
// ============================================================================
// Frame rate monitor package
// Shared widths, codes and transaction types of the frame rate monitor.
// ============================================================================
`default_nettype none

package frm_pkg;

    // Field widths
    localparam int TS_W      = 48;
    localparam int RATE_W    = 12;
    localparam int IDX_W     = 6;
    localparam int MODE_W    = 2;
    localparam int DROP_W    = 40;
    localparam int STUT_W    = 32;
    localparam int HCOUNT_W  = 7;
    localparam int CFG_IDX_W = 1;

    // Quotient bits produced by the divider; the rounded rate never exceeds 4095.
    localparam int QUO_W = 13;

    localparam logic [RATE_W-1:0] RATE_MAX   = 12'd4095;
    localparam logic [RATE_W-1:0] TARGET_RST = 12'd60;
    localparam logic [RATE_W-1:0] THRESH_RST = 12'd4;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STUTTER_THRESHOLD = 1'b1;

    // Request transaction
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TS_W-1:0]   timestamp;
        logic [IDX_W-1:0]  read_index;
    } tick_t;

    // Result transaction
    typedef struct packed {
        logic [RATE_W-1:0]   current_fps;
        logic [RATE_W-1:0]   min_fps;
        logic [RATE_W-1:0]   max_fps;
        logic [DROP_W-1:0]   dropped_total;
        logic [STUT_W-1:0]   stutter_total;
        logic [HCOUNT_W-1:0] history_count;
        logic                sample_recorded;
        logic [RATE_W-1:0]   history_value;
        logic                history_valid;
    } stat_t;

    // Control from the sequencer to the history ring
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [RATE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_index;
    } hist_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/frm_div.sv
// ============================================================================
// Frame rate monitor divider
// Restoring divider that retires one quotient bit per cycle.
// ============================================================================
`default_nettype none

module frm_div #(
    parameter int NUM_W = 50
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [NUM_W-1:0]          num,
    input  wire logic [NUM_W-1:0]          den,
    output logic                           busy,
    output logic                           done,
    output logic [frm_pkg::QUO_W-1:0]      quo
);

    localparam int QUO_W = frm_pkg::QUO_W;
    localparam int DSH_W = NUM_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DSH_W-1:0] rem_ext;
    logic [DSH_W-1:0] diff;
    logic             fits;

    // One trial subtraction of the shifted divisor per cycle
    assign rem_ext = DSH_W'(rem_reg);
    assign diff    = rem_ext - dsh_reg;
    assign fits    = rem_ext >= dsh_reg;

    // Control: busy for one cycle per quotient bit, then a one-cycle done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, shifted divisor and quotient
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= num;
            dsh_reg <= DSH_W'(den) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[NUM_W-1:0];
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while still iterating");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done lasted more than one cycle");
`endif

endmodule

`default_nettype wire

FILE: rtl/frm_hist.sv
// ============================================================================
// Frame rate monitor history ring
// Ring of recorded rates with a fill count and an oldest-first read port.
// ============================================================================
`default_nettype none

module frm_hist #(
    parameter int DEPTH = 64,
    localparam int HELD_W = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire frm_pkg::hist_ctl_t          ctl,
    output logic [HELD_W-1:0]                held,
    output logic [frm_pkg::RATE_W-1:0]       rd_data,
    output logic                             rd_hit
);

    localparam int RATE_W = frm_pkg::RATE_W;
    localparam int IDX_W  = frm_pkg::IDX_W;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
    localparam int CMP_W  = (HELD_W > IDX_W) ? HELD_W : IDX_W;

    logic [RATE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  wp_reg;
    logic [HELD_W-1:0] held_reg;
    logic [RATE_W-1:0] rd_data_reg;
    logic              rd_hit_reg;

    logic              full;
    logic [PTR_W-1:0]  wp_next;
    logic              hit_c;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  pos_wrap;
    logic [PTR_W-1:0]  rd_addr;

    assign full    = held_reg == HELD_W'(DEPTH);
    assign wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // Oldest entry sits at index 0 until the ring wraps, then at the write pointer
    assign hit_c    = CMP_W'(ctl.rd_index) < CMP_W'(held_reg);
    assign pos_sum  = full ? SUM_W'(wp_reg) + SUM_W'(ctl.rd_index) : SUM_W'(ctl.rd_index);
    assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? pos_sum - SUM_W'(DEPTH) : pos_sum;
    assign rd_addr  = pos_wrap[PTR_W-1:0];

    // Pointer and fill count; entries beyond the fill count are never read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            held_reg   <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                wp_reg   <= '0;
                held_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                wp_reg <= wp_next;
                if (!full)
                begin
                    held_reg <= held_reg + 1'b1;
                end
            end
            if (ctl.rd_en)
            begin
                rd_hit_reg <= hit_c;
            end
        end
    end

    // Ring storage with a registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wp_reg] <= ctl.wr_data;
        end
        if (ctl.rd_en && hit_c)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign held    = held_reg;
    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(DEPTH))
        else $error("history fill count beyond ring depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (held_reg == '0 && wp_reg == '0))
        else $error("history clear left entries behind");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_en && !ctl.clear && !full) |=> held_reg == $past(held_reg) + 1'b1)
        else $error("history fill count did not advance on a write");
`endif

endmodule

`default_nettype wire

FILE: rtl/frame_rate_monitor_unit.sv
// ============================================================================
// Frame rate monitor
// Counts frame ticks over windows of at least one second, records the
// rounded frame rate of each window and keeps rate statistics and history.
// ============================================================================
//
//   Channel   Signals                          Direction  Role
//   tick      tick_valid/tick_stall/tick_data  in         tick, clear, read
//   stat      stat_valid/stat_stall/stat_data  out        status after each
//   cfg       cfg_wr_en/cfg_index/cfg_data     in         register writes
//
// A clear or an unused mode goes from idle to the finish state, a history read
// via the read state, and a tick via the tick and, with a window open, the
// check states. A tick that closes a window goes on via the numerator, divide
// and record states; the restoring divider forms the rounded rate in 13 steps.
// One transaction is in flight at a time; tick_stall is high until the
// sequencer returns to idle, and a full, stalled output register holds it.
// Reset clears all statistics; the history ring needs no clearing pass.
// ============================================================================
`default_nettype none

module frame_rate_monitor_unit #(
    parameter int HISTORY_DEPTH    = 64,
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              tick_valid,
    output logic                                   tick_stall,
    input  wire frm_pkg::tick_t                    tick_data,
    output logic                                   stat_valid,
    input  wire logic                              stat_stall,
    output frm_pkg::stat_t                         stat_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [frm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [frm_pkg::RATE_W-1:0]        cfg_data
);

    localparam int TS_W    = frm_pkg::TS_W;
    localparam int RATE_W  = frm_pkg::RATE_W;
    localparam int DROP_W  = frm_pkg::DROP_W;
    localparam int STUT_W  = frm_pkg::STUT_W;
    localparam int HC_W    = frm_pkg::HCOUNT_W;
    localparam int QUO_W   = frm_pkg::QUO_W;
    localparam int DSUM_W  = DROP_W + 1;
    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W  = RATE_W + TPS_W;
    localparam int SUMA_W  = (PROD_W + 1 > TS_W) ? PROD_W + 1 : TS_W;
    localparam int NUM_W   = SUMA_W + 1;
    localparam int HELD_W  = $clog2(HISTORY_DEPTH + 1);
    localparam logic [TPS_W-1:0] TPS_VAL = TPS_W'(TICKS_PER_SECOND);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TICK = 8'b0000_0010,
        ST_CHK  = 8'b0000_0100,
        ST_NUM  = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_REC  = 8'b0010_0000,
        ST_READ = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    frm_pkg::tick_t req_reg;
    frm_pkg::stat_t out_reg;
    logic           out_valid_reg;

    logic [RATE_W-1:0] target_reg;
    logic [RATE_W-1:0] thresh_reg;

    logic              started_reg;
    logic [TS_W-1:0]   wstart_reg;
    logic [RATE_W-1:0] fcount_reg;
    logic [TS_W-1:0]   elapsed_reg;
    logic              borrow_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RATE_W-1:0] last_reg;
    logic [RATE_W-1:0] low_reg;
    logic [RATE_W-1:0] high_reg;
    logic [DROP_W-1:0] drop_reg;
    logic [STUT_W-1:0] stut_reg;
    logic              rec_reg;

    logic              accept;
    logic              load_out;
    logic [TS_W:0]     ts_diff;
    logic [NUM_W-1:0]  div_num;
    logic [NUM_W-1:0]  div_den;
    logic              div_busy;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [RATE_W-1:0] fps_c;
    logic [RATE_W-1:0] shortfall_c;
    logic [DSUM_W-1:0] drop_sum_c;

    frm_pkg::hist_ctl_t hist_ctl;
    logic [HELD_W-1:0]  held;
    logic [RATE_W-1:0]  hist_data;
    logic               hist_hit;
    logic               read_hit_c;

    assign tick_stall = state_reg != ST_IDLE;
    assign accept     = tick_valid && !tick_stall;
    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || !stat_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (tick_data.mode == frm_pkg::MODE_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (tick_data.mode == frm_pkg::MODE_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_TICK: state_next = started_reg ? ST_CHK : ST_FIN;
            ST_CHK:
            begin
                if (borrow_reg || elapsed_reg < TS_W'(TPS_VAL))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:  state_next = div_done ? ST_REC : ST_DIV;
            ST_REC:  state_next = ST_FIN;
            ST_READ: state_next = ST_FIN;
            ST_FIN:  state_next = load_out ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= frm_pkg::TARGET_RST;
            thresh_reg <= frm_pkg::THRESH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                frm_pkg::REG_TARGET_FPS:        target_reg <= cfg_data;
                frm_pkg::REG_STUTTER_THRESHOLD: thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= tick_data;
        end
    end

    // Elapsed time since the window start, with the borrow marking an earlier tick
    assign ts_diff = {1'b0, req_reg.timestamp} - {1'b0, wstart_reg};

    // Rounded rate: (2 * count * tps + elapsed) / (2 * elapsed)
    assign div_num = NUM_W'({prod_reg, 1'b0}) + NUM_W'(elapsed_reg);
    assign div_den = NUM_W'({elapsed_reg, 1'b0});

    frm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_NUM),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Window timing and multiplier stage
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TICK)
        begin
            elapsed_reg <= ts_diff[TS_W-1:0];
            borrow_reg  <= ts_diff[TS_W];
        end
        if (state_reg == ST_CHK)
        begin
            prod_reg <= PROD_W'(fcount_reg) * PROD_W'(TPS_VAL);
        end
    end

    // Clear, frame counting and rate statistics for the window being closed
    assign fps_c       = (div_quo > QUO_W'(frm_pkg::RATE_MAX)) ? frm_pkg::RATE_MAX
                                                               : div_quo[RATE_W-1:0];
    assign shortfall_c = (target_reg > fps_c) ? target_reg - fps_c : '0;
    assign drop_sum_c  = DSUM_W'(drop_reg) + DSUM_W'(shortfall_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            wstart_reg  <= '0;
            fcount_reg  <= '0;
            last_reg    <= '0;
            low_reg     <= frm_pkg::RATE_MAX;
            high_reg    <= '0;
            drop_reg    <= '0;
            stut_reg    <= '0;
            rec_reg     <= 1'b0;
        end
        else if (accept)
        begin
            rec_reg <= 1'b0;
            if (tick_data.mode == frm_pkg::MODE_CLEAR)
            begin
                started_reg <= 1'b0;
                wstart_reg  <= '0;
                fcount_reg  <= '0;
                last_reg    <= '0;
                low_reg     <= frm_pkg::RATE_MAX;
                high_reg    <= '0;
                drop_reg    <= '0;
                stut_reg    <= '0;
            end
        end
        else if (state_reg == ST_TICK)
        begin
            if (!started_reg)
            begin
                started_reg <= 1'b1;
                wstart_reg  <= req_reg.timestamp;
                fcount_reg  <= RATE_W'(1);
            end
            else if (fcount_reg != frm_pkg::RATE_MAX)
            begin
                fcount_reg <= fcount_reg + 1'b1;
            end
        end
        else if (state_reg == ST_REC)
        begin
            last_reg   <= fps_c;
            wstart_reg <= req_reg.timestamp;
            fcount_reg <= '0;
            rec_reg    <= 1'b1;
            if (fps_c < low_reg)
            begin
                low_reg <= fps_c;
            end
            if (fps_c > high_reg)
            begin
                high_reg <= fps_c;
            end
            drop_reg <= drop_sum_c[DROP_W] ? '1 : drop_sum_c[DROP_W-1:0];
            if (shortfall_c >= thresh_reg && stut_reg != '1)
            begin
                stut_reg <= stut_reg + 1'b1;
            end
        end
    end

    // History ring
    always_comb
    begin
        hist_ctl          = '0;
        hist_ctl.clear    = accept && (tick_data.mode == frm_pkg::MODE_CLEAR);
        hist_ctl.wr_en    = state_reg == ST_REC;
        hist_ctl.wr_data  = fps_c;
        hist_ctl.rd_en    = state_reg == ST_READ;
        hist_ctl.rd_index = req_reg.read_index;
    end

    frm_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .held    (held),
        .rd_data (hist_data),
        .rd_hit  (hist_hit)
    );

    assign read_hit_c = (req_reg.mode == frm_pkg::MODE_READ) && hist_hit;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!stat_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.current_fps     <= last_reg;
            out_reg.min_fps         <= (held != '0) ? low_reg : '0;
            out_reg.max_fps         <= high_reg;
            out_reg.dropped_total   <= drop_reg;
            out_reg.stutter_total   <= stut_reg;
            out_reg.history_count   <= HC_W'(held);
            out_reg.sample_recorded <= rec_reg;
            out_reg.history_value   <= read_hit_c ? hist_data : '0;
            out_reg.history_valid   <= read_hit_c;
        end
    end

    assign stat_valid = out_valid_reg;
    assign stat_data  = out_reg;

`ifndef SYNTHESIS
    a_clear_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tick_data.mode == frm_pkg::MODE_CLEAR)
        |=> (!started_reg && drop_reg == '0 && stut_reg == '0 && held == '0))
        else $error("clear left statistics behind");

    a_div_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider running outside the division step");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_valid && stat_data.history_count != '0)
        |-> stat_data.min_fps <= stat_data.max_fps)
        else $error("reported minimum rate above maximum rate");

    a_record_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REC) |-> started_reg)
        else $error("rate recorded before any window was opened");
`endif

endmodule

`default_nettype wire
